@@ hw/rtl/intel_hex_text_encoder_top_defines.svh @@
// Assertion macros shared by the encoder modules.
`ifndef INTEL_HEX_TEXT_ENCODER_TOP_DEFINES_SVH
`define INTEL_HEX_TEXT_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTH
`define IHEX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define IHEX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define IHEX_ASSERT(lbl, prop, msg)
`define IHEX_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/ihex_pkg.sv @@
`timescale 1ns / 1ps
package ihex_pkg;

	localparam int PC_W = 6;

	localparam logic [PC_W-1:0] PC_IDLE  = 6'd0;
	localparam logic [PC_W-1:0] PC_ELA   = 6'd1;
	localparam logic [PC_W-1:0] PC_DREC  = 6'd17;
	localparam logic [PC_W-1:0] PC_BYTES = 6'd26;
	localparam logic [PC_W-1:0] PC_DCS   = 6'd28;
	localparam logic [PC_W-1:0] PC_EOF   = 6'd31;
	localparam logic [PC_W-1:0] PC_LAST  = 6'd42;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;
	localparam logic [7:0] ELA_SUM_BASE   = 8'h06;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last_of_run;
	} out_item_t;

	typedef enum logic [3:0] {
		SRC_CONST,
		SRC_UP_HI,
		SRC_UP_LO,
		SRC_ECS,
		SRC_CNT,
		SRC_AH,
		SRC_AL,
		SRC_BYTE,
		SRC_DCS
	} char_src_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_DISPATCH,
		J_LOOP,
		J_ELA_END,
		J_DREC_END,
		J_END
	} jmp_t;

	typedef struct packed {
		logic       emit;
		char_src_t  src;
		logic       nib_lo;
		logic [7:0] chr;
		jmp_t       jmp;
	} ctl_t;

	typedef struct packed {
		logic       busy;
		logic       accept;
		logic       step;
		logic       last;
		logic       loop_more;
		logic       loop_done;
		char_src_t  src;
		logic       nib_lo;
		logic [7:0] chr;
	} seq_ctl_t;

	typedef struct packed {
		logic advance;
		logic need_ela;
		logic flush;
		logic flush_q;
		logic fin_q;
		logic more;
	} dp_stat_t;

	function automatic ctl_t k(input logic [7:0] c);
		ctl_t w;
		w = '{emit: 1'b1, src: SRC_CONST, nib_lo: 1'b0, chr: c, jmp: J_NEXT};
		return w;
	endfunction

	function automatic ctl_t h(input char_src_t s, input logic lo);
		ctl_t w;
		w = '{emit: 1'b1, src: s, nib_lo: lo, chr: 8'h00, jmp: J_NEXT};
		return w;
	endfunction

	function automatic ctl_t ucode_word(input logic [PC_W-1:0] pc);
		ctl_t w;
		w = '{emit: 1'b0, src: SRC_CONST, nib_lo: 1'b0, chr: 8'h00, jmp: J_DISPATCH};
		case (pc)
			PC_IDLE:           w.jmp = J_DISPATCH;
			PC_ELA:            w = k(CH_COLON);
			PC_ELA + 6'd1:     w = k(CH_0);
			PC_ELA + 6'd2:     w = k(CH_2);
			PC_ELA + 6'd3:     w = k(CH_0);
			PC_ELA + 6'd4:     w = k(CH_0);
			PC_ELA + 6'd5:     w = k(CH_0);
			PC_ELA + 6'd6:     w = k(CH_0);
			PC_ELA + 6'd7:     w = k(CH_0);
			PC_ELA + 6'd8:     w = k(CH_4);
			PC_ELA + 6'd9:     w = h(SRC_UP_HI, 1'b0);
			PC_ELA + 6'd10:    w = h(SRC_UP_HI, 1'b1);
			PC_ELA + 6'd11:    w = h(SRC_UP_LO, 1'b0);
			PC_ELA + 6'd12:    w = h(SRC_UP_LO, 1'b1);
			PC_ELA + 6'd13:    w = h(SRC_ECS, 1'b0);
			PC_ELA + 6'd14:    w = h(SRC_ECS, 1'b1);
			PC_ELA + 6'd15: begin
				w = k(CH_LF);
				w.jmp = J_ELA_END;
			end
			PC_DREC:           w = k(CH_COLON);
			PC_DREC + 6'd1:    w = h(SRC_CNT, 1'b0);
			PC_DREC + 6'd2:    w = h(SRC_CNT, 1'b1);
			PC_DREC + 6'd3:    w = h(SRC_AH, 1'b0);
			PC_DREC + 6'd4:    w = h(SRC_AH, 1'b1);
			PC_DREC + 6'd5:    w = h(SRC_AL, 1'b0);
			PC_DREC + 6'd6:    w = h(SRC_AL, 1'b1);
			PC_DREC + 6'd7:    w = k(CH_0);
			PC_DREC + 6'd8:    w = k(CH_0);
			PC_BYTES:          w = h(SRC_BYTE, 1'b0);
			PC_BYTES + 6'd1: begin
				w = h(SRC_BYTE, 1'b1);
				w.jmp = J_LOOP;
			end
			PC_DCS:            w = h(SRC_DCS, 1'b0);
			PC_DCS + 6'd1:     w = h(SRC_DCS, 1'b1);
			PC_DCS + 6'd2: begin
				w = k(CH_LF);
				w.jmp = J_DREC_END;
			end
			PC_EOF:            w = k(CH_COLON);
			PC_EOF + 6'd1:     w = k(CH_0);
			PC_EOF + 6'd2:     w = k(CH_0);
			PC_EOF + 6'd3:     w = k(CH_0);
			PC_EOF + 6'd4:     w = k(CH_0);
			PC_EOF + 6'd5:     w = k(CH_0);
			PC_EOF + 6'd6:     w = k(CH_0);
			PC_EOF + 6'd7:     w = k(CH_0);
			PC_EOF + 6'd8:     w = k(CH_1);
			PC_EOF + 6'd9:     w = k(CH_F);
			PC_EOF + 6'd10:    w = k(CH_F);
			PC_LAST: begin
				w = k(CH_LF);
				w.jmp = J_END;
			end
			default:           w.jmp = J_DISPATCH;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = CH_0 + {4'h0, n};
		end else begin
			c = HEX_ALPHA_BASE + {4'h0, n};
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/ihex_seq.sv @@
`timescale 1ns / 1ps
`include "intel_hex_text_encoder_top_defines.svh"
module ihex_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ihex_pkg::dp_stat_t stat,
	output ihex_pkg::seq_ctl_t ctl
);
	import ihex_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_n;
	ctl_t            w;
	logic            busy;
	logic            accept;
	logic            step;
	logic            last;
	logic            loop_more;
	logic            loop_done;

	assign w      = ucode_word(pc_q);
	assign busy   = (pc_q != PC_IDLE);
	assign accept = in_valid && !busy;
	assign step   = w.emit && stat.advance;

	always_comb begin
		pc_n      = pc_q;
		last      = 1'b0;
		loop_more = 1'b0;
		loop_done = 1'b0;
		case (w.jmp)
			J_DISPATCH: begin
				if (accept && stat.need_ela) begin
					pc_n = PC_ELA;
				end else if (accept && stat.flush) begin
					pc_n = PC_DREC;
				end else begin
					pc_n = PC_IDLE;
				end
			end
			J_NEXT: begin
				if (step) begin
					pc_n = pc_q + PC_W'(1);
				end
			end
			J_LOOP: begin
				if (step && stat.more) begin
					pc_n      = PC_BYTES;
					loop_more = 1'b1;
				end else if (step) begin
					pc_n      = pc_q + PC_W'(1);
					loop_done = 1'b1;
				end
			end
			J_ELA_END: begin
				if (step && stat.flush_q) begin
					pc_n = PC_DREC;
				end else if (step) begin
					pc_n = PC_IDLE;
					last = 1'b1;
				end
			end
			J_DREC_END: begin
				if (step && stat.fin_q) begin
					pc_n = PC_EOF;
				end else if (step) begin
					pc_n = PC_IDLE;
					last = 1'b1;
				end
			end
			J_END: begin
				if (step) begin
					pc_n = PC_IDLE;
					last = 1'b1;
				end
			end
			default: pc_n = PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_n;
		end
	end

	assign ctl = '{busy: busy, accept: accept, step: step, last: last,
		loop_more: loop_more, loop_done: loop_done, src: w.src,
		nib_lo: w.nib_lo, chr: w.chr};

	`IHEX_ASSERT_NEXT(a_ela_start, accept && stat.need_ela, pc_q == PC_ELA, "ELA record not started")
	`IHEX_ASSERT_NEXT(a_last_idle, last, pc_q == PC_IDLE, "last character did not end the run")
	`IHEX_ASSERT(a_pc_range, pc_q <= PC_LAST, "step counter outside the program")

endmodule

@@ hw/rtl/ihex_dp.sv @@
`timescale 1ns / 1ps
`include "intel_hex_text_encoder_top_defines.svh"
module ihex_dp #(
	parameter int RECORD_BYTES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ihex_pkg::in_item_t  in_data,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	input  logic                out_stall,
	input  ihex_pkg::seq_ctl_t  ctl,
	output ihex_pkg::dp_stat_t  stat,
	output logic                out_valid,
	output ihex_pkg::out_item_t out_data
);
	import ihex_pkg::*;

	localparam int CNT_W = $clog2(RECORD_BYTES + 1);
	localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

	logic [31:0]      base_q;
	logic [31:0]      offset_q;
	logic [31:0]      rec_addr_q;
	logic [15:0]      upper_q;
	logic [CNT_W-1:0] fill_q;
	logic [7:0]       sum_q;
	logic [7:0]       store_q [RECORD_BYTES];

	logic [15:0]      ela_up_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       esum_q;
	logic             flush_q;
	logic             fin_q;
	logic [IDX_W-1:0] bidx_q;

	out_item_t        out_q;
	logic             out_valid_q;

	logic             first;
	logic [31:0]      addr_new;
	logic             need_ela;
	logic [CNT_W-1:0] fill_inc;
	logic             flush;
	logic [7:0]       sum_n;
	logic             more;
	logic             advance;
	logic [7:0]       ecs;
	logic [7:0]       dcs;
	logic [7:0]       sel;
	logic [7:0]       char_n;

	assign first    = (fill_q == '0);
	assign addr_new = base_q + offset_q;
	assign need_ela = first && (addr_new[31:16] != upper_q);
	assign fill_inc = fill_q + CNT_W'(1);
	assign flush    = (fill_inc >= CNT_W'(RECORD_BYTES)) || in_data.final_byte;
	assign sum_n    = (first ? 8'h00 : sum_q) + in_data.data_byte;
	assign more     = ((CNT_W'(bidx_q) + CNT_W'(1)) < cnt_q);
	assign advance  = !out_valid_q || !out_stall;

	assign ecs = 8'h00 - (ELA_SUM_BASE + ela_up_q[15:8] + ela_up_q[7:0]);
	assign dcs = 8'h00 - (8'(cnt_q) + rec_addr_q[15:8] + rec_addr_q[7:0] + esum_q);

	always_comb begin
		case (ctl.src)
			SRC_UP_HI: sel = ela_up_q[15:8];
			SRC_UP_LO: sel = ela_up_q[7:0];
			SRC_ECS:   sel = ecs;
			SRC_CNT:   sel = 8'(cnt_q);
			SRC_AH:    sel = rec_addr_q[15:8];
			SRC_AL:    sel = rec_addr_q[7:0];
			SRC_BYTE:  sel = store_q[bidx_q];
			SRC_DCS:   sel = dcs;
			default:   sel = 8'h00;
		endcase
		if (ctl.src == SRC_CONST) begin
			char_n = ctl.chr;
		end else if (ctl.nib_lo) begin
			char_n = hex_char(sel[3:0]);
		end else begin
			char_n = hex_char(sel[7:4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			offset_q    <= '0;
			upper_q     <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			flush_q     <= 1'b0;
			fin_q       <= 1'b0;
			bidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (ctl.accept) begin
				fill_q   <= flush ? '0 : fill_inc;
				sum_q    <= flush ? 8'h00 : sum_n;
				offset_q <= in_data.final_byte ? 32'h0 : offset_q + 32'h1;
				flush_q  <= flush;
				fin_q    <= in_data.final_byte;
				if (in_data.final_byte) begin
					upper_q <= '0;
				end else if (need_ela) begin
					upper_q <= addr_new[31:16];
				end
			end
			if (ctl.loop_more) begin
				bidx_q <= bidx_q + IDX_W'(1);
			end else if (ctl.loop_done) begin
				bidx_q <= '0;
			end
			if (ctl.step) begin
				out_valid_q <= 1'b1;
			end else if (advance) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			store_q[fill_q[IDX_W-1:0]] <= in_data.data_byte;
			cnt_q  <= fill_inc;
			esum_q <= sum_n;
			if (first) begin
				rec_addr_q <= addr_new;
			end
			if (need_ela) begin
				ela_up_q <= addr_new[31:16];
			end
		end
		if (ctl.step) begin
			out_q <= '{text_char: char_n, last_of_run: ctl.last};
		end
	end

	assign stat = '{advance: advance, need_ela: need_ela, flush: flush,
		flush_q: flush_q, fin_q: fin_q, more: more};

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`IHEX_ASSERT_NEXT(a_flush_clears, ctl.accept && flush, fill_q == '0, "record not closed")
	`IHEX_ASSERT(a_bidx_range, (bidx_q == '0) || (CNT_W'(bidx_q) < cnt_q), "byte index past count")
	`IHEX_ASSERT_NEXT(a_step_shows, ctl.step, out_valid_q, "character lost")

endmodule

@@ hw/rtl/intel_hex_text_encoder_top.sv @@
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// input     in_valid / in_stall     in_data   (data_byte, final_byte)
// output    out_valid / out_stall   out_data  (text_char, last_of_run)
// config    cfg_we                  cfg_wdata (base_address)
// A word that neither closes a record nor needs a new upper address emits nothing.
// Other words hold in_stall high while they emit an extended address record on a
// new upper address, the closed data record, and the end-of-file record if final.
// The step counter of the microcode sequencer emits at most one character per cycle.
// Reset is asynchronous and active low; the record store needs no clearing pass.
// Output stall holds the sequencer on the current character.
module intel_hex_text_encoder_top #(
	parameter int RECORD_BYTES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ihex_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ihex_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata
);
	import ihex_pkg::*;

	seq_ctl_t ctl;
	dp_stat_t stat;

	ihex_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctl      (ctl)
	);

	ihex_dp #(
		.RECORD_BYTES (RECORD_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_stall (out_stall),
		.ctl       (ctl),
		.stat      (stat),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	assign in_stall = ctl.busy;

endmodule

@@ bench/tb_intel_hex_text_encoder_top.sv @@
`timescale 1ns / 1ps
module tb_intel_hex_text_encoder_top;
	import ihex_pkg::*;

	localparam int RECORD_LEN = 16;
	localparam logic [7:0] ASCII_A = 8'h41;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	intel_hex_text_encoder_top #(
		.RECORD_BYTES(RECORD_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	logic [31:0] load_base;
	logic [7:0]  rec_store [RECORD_LEN];
	logic [4:0]  fill_cnt;
	logic [31:0] img_offset;
	logic [31:0] rec_addr;
	logic [15:0] last_upper;
	logic [7:0]  rec_sum;
	logic [7:0]  run_text[$];
	out_item_t   hex_text_due[$];
	in_item_t    pending_words[$];
	out_item_t   due_char;
	logic        word_taken;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          mismatch_count;

	always #2 clk = ~clk;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) begin
			c = CH_0 + {4'h0, v};
		end else begin
			c = ASCII_A + {4'h0, v} - 8'd10;
		end
		return c;
	endfunction

	task automatic put_hex8(input logic [7:0] v);
		run_text.push_back(hex_digit(v[7:4]));
		run_text.push_back(hex_digit(v[3:0]));
	endtask

	task automatic put_string(input string s);
		for (int i = 0; i < s.len(); i++) begin
			run_text.push_back(s[i]);
		end
	endtask

	task automatic encode_word(input in_item_t w);
		logic [15:0] up;
		logic [15:0] lo;
		logic [7:0]  csum;
		out_item_t   r;
		run_text.delete();
		if (fill_cnt == 5'd0) begin
			rec_addr = load_base + img_offset;
			rec_sum = 8'h00;
			up = rec_addr[31:16];
			if (up != last_upper) begin
				last_upper = up;
				put_string(":02000004");
				put_hex8(up[15:8]);
				put_hex8(up[7:0]);
				put_hex8(8'h00 - (8'h06 + up[15:8] + up[7:0]));
				run_text.push_back(CH_LF);
			end
		end
		rec_store[fill_cnt[3:0]] = w.data_byte;
		rec_sum = rec_sum + w.data_byte;
		fill_cnt = fill_cnt + 5'd1;
		img_offset = img_offset + 32'd1;
		if (fill_cnt >= RECORD_LEN || w.final_byte) begin
			lo = rec_addr[15:0];
			csum = {3'b000, fill_cnt} + lo[15:8] + lo[7:0] + rec_sum;
			run_text.push_back(CH_COLON);
			put_hex8({3'b000, fill_cnt});
			put_hex8(lo[15:8]);
			put_hex8(lo[7:0]);
			put_hex8(8'h00);
			for (int i = 0; i < fill_cnt; i++) begin
				put_hex8(rec_store[i]);
			end
			put_hex8(8'h00 - csum);
			run_text.push_back(CH_LF);
			fill_cnt = 5'd0;
			rec_sum = 8'h00;
		end
		if (w.final_byte) begin
			put_string(":00000001FF");
			run_text.push_back(CH_LF);
			fill_cnt = 5'd0;
			img_offset = 32'd0;
			last_upper = 16'h0000;
			rec_sum = 8'h00;
		end
		for (int i = 0; i < run_text.size(); i++) begin
			r.text_char = run_text[i];
			r.last_of_run = (i == run_text.size() - 1);
			hex_text_due.push_back(r);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				encode_word(in_data);
				word_taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (hex_text_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("unexpected character: got %h last %b",
							out_data.text_char, out_data.last_of_run);
					end
				end else begin
					due_char = hex_text_due.pop_front();
					if (out_data.text_char !== due_char.text_char ||
						out_data.last_of_run !== due_char.last_of_run) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("character mismatch: expected %h last %b, got %h last %b",
								due_char.text_char, due_char.last_of_run,
								out_data.text_char, out_data.last_of_run);
						end
					end
				end
			end
		end
	end

	// A new word is presented only once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || word_taken) begin
				word_taken = 1'b0;
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= pending_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic queue_word(input logic [7:0] b, input logic fin);
		in_item_t w;
		w.data_byte = b;
		w.final_byte = fin;
		pending_words.push_back(w);
	endtask

	task automatic queue_image(input int len);
		for (int i = 0; i < len; i++) begin
			queue_word(8'($urandom_range(255)), i == len - 1);
		end
	endtask

	task automatic settle();
		while (pending_words.size() != 0 || in_valid || hex_text_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(negedge clk);
	endtask

	task automatic write_base(input logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		load_base = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_base();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(5))
			0: v = 32'h0000_0000;
			1: v = 32'hFFFF_FFFF;
			2: v = {v[31:16], 12'hFFF, v[3:0]};
			3: v = {16'h0000, v[15:0]};
			4: v = {16'h0000, 12'hFFF, v[3:0]};
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		int seg_words;
		int len;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 32'h0;
		word_taken = 1'b0;
		mismatch_count = 0;
		load_base = 32'h0;
		fill_cnt = 5'd0;
		img_offset = 32'h0;
		rec_addr = 32'h0;
		last_upper = 16'h0;
		rec_sum = 8'h0;
		send_idle_pct = 26;
		recv_idle_pct = 77;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// A one-word image, then a full record closed by a one-word record.
		write_base(32'h0000_0000);
		queue_word(8'hFF, 1'b1);
		queue_word(8'h00, 1'b0);
		queue_word(8'hFF, 1'b0);
		queue_word(8'h55, 1'b0);
		queue_word(8'hAA, 1'b0);
		for (int i = 0; i < 12; i++) begin
			queue_word(8'h01 << (i % 8), 1'b0);
		end
		queue_word(8'h7E, 1'b1);
		settle();

		// The top of the address space: the record wraps past zero.
		write_base(32'hFFFF_FFFF);
		for (int i = 0; i < 8; i++) begin
			queue_word(8'(8'h10 * i + i), i == 7);
		end
		settle();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 77 : 0;
			recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 26 : 0;
			for (int seg = 0; seg < 4; seg++) begin
				write_base(pick_base());
				seg_words = 0;
				while (seg_words < 16) begin
					len = ($urandom_range(7) == 0) ? $urandom_range(17, 48)
						: $urandom_range(1, 16);
					queue_image(len);
					seg_words += len;
				end
				settle();
			end
		end

		if (mismatch_count == 0 && hex_text_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_seq.sv
hw/rtl/ihex_dp.sv
hw/rtl/intel_hex_text_encoder_top.sv
bench/tb_intel_hex_text_encoder_top.sv
